// ----- design/ffc_pkg.sv -----
// Package for the float format converter: kind codes, format constants.
// Depends on nothing.
package ffc_pkg;
    localparam logic [2:0] KIND_Q2D = 3'd0;
    localparam logic [2:0] KIND_Q2S = 3'd1;
    localparam logic [2:0] KIND_D2S = 3'd2;
    localparam logic [2:0] KIND_S2D = 3'd3;
    localparam logic [2:0] KIND_D2Q = 3'd4;
    localparam logic [2:0] KIND_S2Q = 3'd5;

    localparam int Q_BIAS = 16383;
    localparam int D_BIAS = 1023;
    localparam int S_BIAS = 127;

    localparam logic [63:0] D_QNAN = 64'h7ff8000000000000;
    localparam logic [63:0] D_INF  = 64'h7ff0000000000000;
    localparam logic [31:0] S_QNAN = 32'h7fc00000;
    localparam logic [31:0] S_INF  = 32'h7f800000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] operand_hi;
        logic [63:0] operand_lo;
    } ffc_req_t;

    typedef struct packed {
        logic [63:0] result_hi;
        logic [63:0] result_lo;
    } ffc_rsp_t;

    // Narrowing after stage 1: sign, biased target exponent, significand
    // with leading one at bit 52 (single: bit 23), guard, sticky.
    typedef struct packed {
        logic        special;   // result already final in res
        logic [63:0] res;
        logic        dbl;       // target is binary64
        logic        sign;
        logic signed [16:0] e;
        logic [52:0] sig;
        logic        guard;
        logic        sticky;
    } ffc_nar_t;
endpackage

// ----- design/ffc_if.sv -----
// Valid/ready channel interfaces for the float format converter.
// Depends on ffc_pkg.
interface ffc_req_if;
    logic            valid;
    logic            ready;
    ffc_pkg::ffc_req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ffc_rsp_if;
    logic            valid;
    logic            ready;
    ffc_pkg::ffc_rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/float_format_converter_unit.sv -----
// Top level of the float format converter: three-stage pipeline.
// Depends on ffc_pkg and ffc_if.
//
// Usage: requests arrive on req (kind, operand_hi, operand_lo) and results
// leave on rsp (result_hi, result_lo), one result per request, in order.
// Both channels use valid/ready; a transfer happens when both are high.
// Pipeline: stage 1 unpacks and aligns (narrowing: first rounding inputs;
// widening: subnormal normalize), stage 2 does the first rounding and
// the subnormal shift, stage 3 does the second rounding and packing.
// Throughput is one request per cycle while the receiver is ready; a stage
// moves whenever the stage after it is empty or moving, so a stalled receiver
// freezes only the stages that are full.
// Reset clears all valid bits; payload registers are not reset.
// When the receiver stalls, the output holds stable and the pipeline
// fills, then req.ready drops; nothing is lost or repeated.
module float_format_converter_unit (
    input  logic clk,
    input  logic rst_n,
    ffc_req_if.sink   req,
    ffc_rsp_if.source rsp
);
    // Stage control
    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;
    assign adv3 = !v3_reg || rsp.ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign req.ready = adv1;

    // ---------------- stage 1: unpack ----------------
    ffc_pkg::ffc_nar_t n1_next, n1_reg;
    logic        w1_next, w1_reg;          // widening path
    logic [63:0] wh1_next, wl1_next, wh1_reg, wl1_reg;

    logic [63:0] hi, lo;
    logic [2:0]  kind;
    logic        qsign, dsign, ssign;
    logic [14:0] qexp;
    logic [10:0] dexp;
    logic [7:0]  sexp;
    logic [47:0] qf;
    logic [51:0] df;
    logic [22:0] sf;
    logic        qnan;

    // widening unpack
    logic        wsrc_d, wsign, wspec, wzero, wnan;
    logic signed [16:0] wexp;
    logic [51:0] wfrac;   // left-justified fraction, 52 bits
    logic [51:0] wraw;
    logic [5:0]  lz;
    logic        found;

    always_comb
    begin
        hi = req.data.operand_hi;
        lo = req.data.operand_lo;
        kind = req.data.kind;
        qsign = hi[63]; qexp = hi[62:48]; qf = hi[47:0];
        dsign = lo[63]; dexp = lo[62:52]; df = lo[51:0];
        ssign = lo[31]; sexp = lo[30:23]; sf = lo[22:0];
        qnan = (qf != 48'd0) || (lo != 64'd0);

        n1_next = '0;
        n1_next.dbl = (kind == ffc_pkg::KIND_Q2D);
        case (kind)
            ffc_pkg::KIND_Q2D:
            begin
                n1_next.sign = qsign;
                if (qexp == 15'h7fff)
                begin
                    n1_next.special = 1'b1;
                    n1_next.res = {qsign, 63'd0} |
                        (qnan ? ffc_pkg::D_QNAN : ffc_pkg::D_INF);
                end
                else if (qexp == 15'd0)
                begin
                    n1_next.special = 1'b1;
                    n1_next.res = {qsign, 63'd0};
                end
                n1_next.e = 17'($signed({2'b0, qexp})) -
                    17'(ffc_pkg::Q_BIAS - ffc_pkg::D_BIAS);
                n1_next.sig = {1'b1, qf, lo[63:60]};
                n1_next.guard = lo[59];
                n1_next.sticky = lo[58:0] != 59'd0;
            end
            ffc_pkg::KIND_Q2S:
            begin
                n1_next.sign = qsign;
                if (qexp == 15'h7fff)
                begin
                    n1_next.special = 1'b1;
                    n1_next.res = {32'd0, qsign, 31'd0} |
                        {32'd0, (qnan ? ffc_pkg::S_QNAN : ffc_pkg::S_INF)};
                end
                else if (qexp == 15'd0)
                begin
                    n1_next.special = 1'b1;
                    n1_next.res = {32'd0, qsign, 31'd0};
                end
                n1_next.e = 17'($signed({2'b0, qexp})) -
                    17'(ffc_pkg::Q_BIAS - ffc_pkg::S_BIAS);
                n1_next.sig = {29'd0, 1'b1, qf[47:25]};
                n1_next.guard = qf[24];
                n1_next.sticky = (qf[23:0] != 24'd0) || (lo != 64'd0);
            end
            ffc_pkg::KIND_D2S:
            begin
                n1_next.sign = dsign;
                if (dexp == 11'h7ff)
                begin
                    n1_next.special = 1'b1;
                    n1_next.res = {32'd0, dsign, 31'd0} |
                        {32'd0, ((df != 52'd0) ? ffc_pkg::S_QNAN : ffc_pkg::S_INF)};
                end
                else if (dexp == 11'd0)
                begin
                    n1_next.special = 1'b1;
                    n1_next.res = {32'd0, dsign, 31'd0};
                end
                n1_next.e = 17'($signed({6'b0, dexp})) -
                    17'(ffc_pkg::D_BIAS - ffc_pkg::S_BIAS);
                n1_next.sig = {29'd0, 1'b1, df[51:29]};
                n1_next.guard = df[28];
                n1_next.sticky = df[27:0] != 28'd0;
            end
            default:
            begin
                n1_next.special = 1'b1;
                n1_next.res = '0;
            end
        endcase

        // widening: find the leading one of a subnormal fraction
        wsrc_d = (kind == ffc_pkg::KIND_D2Q);
        wsign = wsrc_d ? dsign : ssign;
        wraw = wsrc_d ? df : {sf, 29'd0};
        wnan = 1'b0; wzero = 1'b0; wspec = 1'b0;
        lz = '0; found = 1'b0;
        for (int i = 51; i >= 0; i--)
        begin
            if (!found && wraw[i])
            begin
                found = 1'b1;
                lz = 6'(51 - i);
            end
        end
        wexp = '0;
        wfrac = '0;
        if (wsrc_d ? (dexp == 11'h7ff) : (sexp == 8'hff))
        begin
            wspec = 1'b1;
            wnan = wraw != 52'd0;
        end
        else if (wsrc_d ? (dexp == 11'd0) : (sexp == 8'd0))
        begin
            if (wraw == 52'd0)
                wzero = 1'b1;
            else
            begin
                wexp = (wsrc_d ? 17'(1 - ffc_pkg::D_BIAS) : 17'(1 - ffc_pkg::S_BIAS))
                    - 17'($signed({11'd0, lz})) - 17'sd1;
                wfrac = wraw << (lz + 6'd1);
            end
        end
        else
        begin
            wexp = wsrc_d ? 17'($signed({6'd0, dexp})) - 17'(ffc_pkg::D_BIAS)
                          : 17'($signed({9'd0, sexp})) - 17'(ffc_pkg::S_BIAS);
            wfrac = wraw;
        end

        w1_next = 1'b0; wh1_next = '0; wl1_next = '0;
        if (kind == ffc_pkg::KIND_D2Q || kind == ffc_pkg::KIND_S2Q)
        begin
            w1_next = 1'b1;
            if (wspec)
                wh1_next = {wsign, 15'h7fff, wnan, 47'd0};
            else if (wzero)
                wh1_next = {wsign, 63'd0};
            else
            begin
                wh1_next = {wsign, 15'(wexp + 17'(ffc_pkg::Q_BIAS)), wfrac[51:4]};
                wl1_next = {wfrac[3:0], 60'd0};
            end
        end
        else if (kind == ffc_pkg::KIND_S2D)
        begin
            w1_next = 1'b1;
            if (wspec)
                wl1_next = {wsign, 63'd0} | (wnan ? ffc_pkg::D_QNAN : ffc_pkg::D_INF);
            else if (wzero)
                wl1_next = {wsign, 63'd0};
            else
                wl1_next = {wsign, 11'(wexp + 17'(ffc_pkg::D_BIAS)), wfrac};
        end
    end

    // ---------------- stage 2: first rounding, subnormal shift ----------------
    logic        sp2_next, sp2_reg;
    logic [63:0] r2_next, r2_reg;       // final value if sp2
    logic        dbl2_reg, sign2_reg;
    logic signed [16:0] e2_next, e2_reg;
    logic [53:0] sig2_next, sig2_reg;   // rounded significand
    logic [5:0]  sh2_next, sh2_reg;     // subnormal shift, 0 = normal
    logic [63:0] wh2_reg;
    logic [53:0] sigr;
    logic signed [16:0] er;
    logic [5:0]  fb;
    logic signed [16:0] emax;

    always_comb
    begin
        fb = n1_reg.dbl ? 6'd52 : 6'd23;
        emax = n1_reg.dbl ? 17'sd2047 : 17'sd255;
        sigr = {1'b0, n1_reg.sig} +
            54'(n1_reg.guard && (n1_reg.sticky || n1_reg.sig[0]));
        er = n1_reg.e;
        if (sigr[fb + 6'd1])
        begin
            sigr = sigr >> 1;
            er = er + 17'sd1;
        end
        sp2_next = 1'b0; r2_next = '0; sh2_next = '0;
        e2_next = er; sig2_next = sigr;
        if (w1_reg)
        begin
            sp2_next = 1'b1;
            r2_next = wl1_reg;
        end
        else if (n1_reg.special)
        begin
            sp2_next = 1'b1;
            r2_next = n1_reg.res;
        end
        else if (er >= emax)
        begin
            sp2_next = 1'b1;
            r2_next = n1_reg.dbl ? {n1_reg.sign, 63'd0} | ffc_pkg::D_INF
                                 : {32'd0, n1_reg.sign, 31'd0} | {32'd0, ffc_pkg::S_INF};
        end
        else if (er <= 17'sd0)
        begin
            if ((17'sd1 - er) > 17'($signed({11'd0, fb})) + 17'sd2)
            begin
                sp2_next = 1'b1;
                r2_next = n1_reg.dbl ? {n1_reg.sign, 63'd0} : {32'd0, n1_reg.sign, 31'd0};
            end
            else
                sh2_next = 6'(17'sd1 - er);
        end
    end

    // ---------------- stage 3: second rounding and pack ----------------
    ffc_pkg::ffc_rsp_t out_next, out_reg;
    logic [53:0] m3, dmask;
    logic        g3, st3;
    logic [63:0] sb3;

    always_comb
    begin
        sb3 = dbl2_reg ? {sign2_reg, 63'd0} : {32'd0, sign2_reg, 31'd0};
        dmask = (54'd1 << sh2_reg) - 54'd1;
        m3 = sig2_reg >> sh2_reg;
        g3 = 1'b0; st3 = 1'b0;
        if (sh2_reg != 6'd0)
        begin
            g3 = sig2_reg[sh2_reg - 6'd1];
            st3 = (sig2_reg & (dmask >> 1)) != 54'd0;
        end
        out_next.result_hi = wh2_reg;
        if (sp2_reg)
            out_next.result_lo = r2_reg;
        else if (sh2_reg != 6'd0)
            out_next.result_lo = sb3 | 64'(m3 + 54'(g3 && (st3 || m3[0])));
        else if (dbl2_reg)
            out_next.result_lo = sb3 | {1'b0, e2_reg[10:0], sig2_reg[51:0]};
        else
            out_next.result_lo = sb3 | {33'd0, e2_reg[7:0], sig2_reg[22:0]};
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= req.valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            n1_reg  <= n1_next;
            w1_reg  <= w1_next;
            wh1_reg <= wh1_next;
            wl1_reg <= wl1_next;
        end
        if (adv2)
        begin
            sp2_reg   <= sp2_next;
            r2_reg    <= r2_next;
            dbl2_reg  <= n1_reg.dbl;
            sign2_reg <= n1_reg.sign;
            e2_reg    <= e2_next;
            sig2_reg  <= sig2_next;
            sh2_reg   <= sh2_next;
            wh2_reg   <= wh1_reg;
        end
        if (adv3)
            out_reg <= out_next;
    end

    assign rsp.valid = v3_reg;
    assign rsp.data  = out_reg;
endmodule

// ----- design/ffc_checker.sv -----
// Port-level checker for the float format converter, bound to the top.
// Depends on ffc_pkg and ffc_if.
module ffc_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input ffc_pkg::ffc_rsp_t rsp_data
);
    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("stalled result changed");

    // Accept requests whenever the receiver is ready
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_ready |-> req_ready)
        else $error("pipeline blocked while output drains");

    // An accepted request produces a valid result when the receiver stays ready in between
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
        else $error("result missing after latency");

    // Negative binary32 results (sign at bit 31) keep result_hi clear
    a_hi: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.result_lo[63:32] == 32'd0 && rsp_data.result_lo[31]
        |-> rsp_data.result_hi == 64'd0)
        else $error("upper half set on narrow result");
endmodule

bind float_format_converter_unit ffc_checker u_ffc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

// ----- sim/ffc_conv_pred.sv -----
// Conversion predictor for the float format converter testbench.
// Depends on ffc_pkg; computes expected result bits for one request.
package ffc_conv_pred;
    import ffc_pkg::*;

    typedef enum int {CL_ZERO, CL_FINITE, CL_INF, CL_NAN} fclass_e;

    typedef struct {
        logic    sign;
        fclass_e cls;
        int      exp;
        logic [63:0] frac;
    } fsplit_t;

    // Round to nearest even, then pack with overflow and subnormal handling.
    function automatic logic [63:0] round_pack(logic [63:0] sb, int e, logic [63:0] sig,
                                                bit g, bit st, int fbits, int emax);
        logic [63:0] m;
        logic [63:0] dropped;
        int sh;
        bit g2;
        bit st2;
        if (g && (st || sig[0]))
            sig = sig + 1;
        if (sig == (64'd1 << (fbits + 1)))
        begin
            sig = sig >> 1;
            e = e + 1;
        end
        if (e >= emax)
            return sb | (64'(emax) << fbits);
        if (e <= 0)
        begin
            sh = 1 - e;
            if (sh > fbits + 2)
                return sb;
            dropped = sig & ((64'd1 << sh) - 1);
            m = sig >> sh;
            g2 = dropped[sh - 1];
            st2 = (dropped & ((64'd1 << (sh - 1)) - 1)) != 0;
            if (g2 && (st2 || m[0]))
                m = m + 1;
            return sb | m;
        end
        return sb | (64'(e) << fbits) | (sig & ((64'd1 << fbits) - 1));
    endfunction

    // Split a binary64 or binary32 pattern, normalizing subnormals.
    function automatic fsplit_t split_narrow_fmt(logic [63:0] bits, int fbits, int ebits,
                                                 int bias);
        fsplit_t u;
        logic [63:0] emask;
        logic [63:0] fmask;
        logic [63:0] ef;
        logic [63:0] fr;
        int sh;
        emask = (64'd1 << ebits) - 1;
        fmask = (64'd1 << fbits) - 1;
        ef = (bits >> fbits) & emask;
        fr = bits & fmask;
        u.sign = bits[fbits + ebits];
        u.exp = 0;
        u.frac = '0;
        sh = 0;
        if (ef == emask)
        begin
            u.cls = (fr != 0) ? CL_NAN : CL_INF;
            return u;
        end
        if (ef == 0)
        begin
            if (fr == 0)
            begin
                u.cls = CL_ZERO;
                return u;
            end
            while (fr[fbits] == 1'b0 && sh < fbits)
            begin
                fr = fr << 1;
                sh++;
            end
            u.exp = 1 - bias - sh;
        end
        else
            u.exp = int'(ef) - bias;
        u.cls = CL_FINITE;
        u.frac = (fr & fmask) << (64 - fbits);
        return u;
    endfunction

    function automatic ffc_rsp_t widen_quad(fsplit_t u);
        ffc_rsp_t r;
        logic [63:0] s;
        s = {u.sign, 63'd0};
        r.result_lo = '0;
        case (u.cls)
            CL_NAN:  r.result_hi = s | 64'h7fff800000000000;
            CL_INF:  r.result_hi = s | 64'h7fff000000000000;
            CL_ZERO: r.result_hi = s;
            default:
            begin
                r.result_hi = s | (64'(u.exp + Q_BIAS) << 48) | (u.frac >> 16);
                r.result_lo = u.frac << 48;
            end
        endcase
        return r;
    endfunction

    function automatic logic [63:0] widen_double(fsplit_t u);
        logic [63:0] s;
        s = {u.sign, 63'd0};
        case (u.cls)
            CL_NAN:  return s | D_QNAN;
            CL_INF:  return s | D_INF;
            CL_ZERO: return s;
            default: return s | (64'(u.exp + D_BIAS) << 52) | (u.frac >> 12);
        endcase
    endfunction

    function automatic logic [63:0] narrow_quad(logic [63:0] hi, logic [63:0] lo, bit to_s);
        logic [63:0] sb;
        int qexp;
        logic [63:0] fhi;
        bit is_nan;
        qexp = int'(hi[62:48]);
        fhi = {16'd0, hi[47:0]};
        is_nan = (fhi | lo) != 0;
        if (to_s)
        begin
            sb = {32'd0, hi[63], 31'd0};
            if (qexp == 'h7fff)
                return sb | (is_nan ? {32'd0, S_QNAN} : {32'd0, S_INF});
            if (qexp == 0)
                return sb;
            return round_pack(sb, qexp - Q_BIAS + S_BIAS, (64'd1 << 23) | (fhi >> 25),
                              fhi[24], (fhi[23:0] != 0) || (lo != 0), 23, 255);
        end
        sb = {hi[63], 63'd0};
        if (qexp == 'h7fff)
            return sb | (is_nan ? D_QNAN : D_INF);
        if (qexp == 0)
            return sb;
        return round_pack(sb, qexp - Q_BIAS + D_BIAS, (64'd1 << 52) | (fhi << 4) | (lo >> 60),
                          lo[59], (lo & 64'h07ffffffffffffff) != 0, 52, 2047);
    endfunction

    function automatic logic [63:0] narrow_double(logic [63:0] a);
        logic [63:0] sb;
        int dexp;
        logic [63:0] frac;
        sb = {32'd0, a[63], 31'd0};
        dexp = int'(a[62:52]);
        frac = {12'd0, a[51:0]};
        if (dexp == 'h7ff)
            return sb | ((frac != 0) ? {32'd0, S_QNAN} : {32'd0, S_INF});
        if (dexp == 0)
            return sb;
        return round_pack(sb, dexp - D_BIAS + S_BIAS, ((64'd1 << 52) | frac) >> 29,
                          frac[28], frac[27:0] != 0, 23, 255);
    endfunction

    // Expected result for one request.
    function automatic ffc_rsp_t convert_expected(ffc_req_t q);
        ffc_rsp_t r;
        r = '0;
        case (q.kind)
            KIND_Q2D: r.result_lo = narrow_quad(q.operand_hi, q.operand_lo, 0);
            KIND_Q2S: r.result_lo = narrow_quad(q.operand_hi, q.operand_lo, 1);
            KIND_D2S: r.result_lo = narrow_double(q.operand_lo);
            KIND_S2D: r.result_lo = widen_double(
                split_narrow_fmt({32'd0, q.operand_lo[31:0]}, 23, 8, S_BIAS));
            KIND_D2Q: r = widen_quad(split_narrow_fmt(q.operand_lo, 52, 11, D_BIAS));
            KIND_S2Q: r = widen_quad(
                split_narrow_fmt({32'd0, q.operand_lo[31:0]}, 23, 8, S_BIAS));
            default:  r = '0;
        endcase
        return r;
    endfunction
endpackage

// ----- sim/float_format_converter_unit_tb.sv -----
// Testbench top for float_format_converter_unit: directed and random
// conversions checked against ffc_conv_pred. Depends on ffc_pkg, ffc_if, ffc_conv_pred.
module float_format_converter_unit_tb;
    import ffc_pkg::*;
    import ffc_conv_pred::*;

    localparam int RANDOM_REQS = 1600;
    localparam int STALL_LIMIT = 2000;

    logic clk;
    logic rst_n;
    ffc_req_if req ();
    ffc_rsp_if rsp ();

    ffc_req_t pending_reqs[$];
    ffc_rsp_t expected_results[$];
    int       error_count;
    int       results_seen;
    int       idle_cycles;
    bit       quiet_window;
    int       cycle_count;

    float_format_converter_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always #10 clk = ~clk;

    // Build a random operand biased toward interesting exponents.
    function automatic ffc_req_t random_request();
        ffc_req_t q;
        int pick;
        q.kind = 3'($urandom_range(0, 7));
        if (q.kind > KIND_S2Q && $urandom_range(0, 3) != 0)
            q.kind = 3'($urandom_range(0, 5));
        q.operand_hi = {$urandom, $urandom};
        q.operand_lo = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        case (q.kind)
            KIND_Q2D, KIND_Q2S:
            begin
                // near target range, overflow edge, underflow edge, specials
                if (pick < 3)
                    q.operand_hi[62:48] = 15'(Q_BIAS + $urandom_range(0, 60) - 30);
                else if (pick < 5)
                    q.operand_hi[62:48] = 15'(Q_BIAS + ((q.kind == KIND_Q2S) ? 127 : 1023)
                                               + $urandom_range(0, 4) - 2);
                else if (pick < 8)
                    q.operand_hi[62:48] = 15'(Q_BIAS - ((q.kind == KIND_Q2S) ? 126 : 1022)
                                               - $urandom_range(0, 60) + 2);
                else if (pick == 8)
                    q.operand_hi[62:48] = (pick & 1) ? 15'h7fff : 15'($urandom_range(0, 1)
                                                                  ? 'h7fff : 0);
                if ($urandom_range(0, 5) == 0)
                    q.operand_hi[47:0] = '0;
                if ($urandom_range(0, 5) == 0)
                    q.operand_lo = $urandom_range(0, 1) ? '0 : 64'h0800000000000000;
            end
            KIND_D2S:
            begin
                if (pick < 3)
                    q.operand_lo[62:52] = 11'(D_BIAS + $urandom_range(0, 60) - 30);
                else if (pick < 5)
                    q.operand_lo[62:52] = 11'(D_BIAS + 127 + $urandom_range(0, 4) - 2);
                else if (pick < 8)
                    q.operand_lo[62:52] = 11'(D_BIAS - 126 - $urandom_range(0, 30) + 2);
                else if (pick == 8)
                    q.operand_lo[62:52] = $urandom_range(0, 1) ? 11'h7ff : 11'h0;
                if ($urandom_range(0, 5) == 0)
                    q.operand_lo[28:0] = $urandom_range(0, 1) ? 29'h10000000 : 29'h0;
            end
            KIND_D2Q:
            begin
                if (pick < 2)
                    q.operand_lo[62:52] = $urandom_range(0, 1) ? 11'h7ff : 11'h0;
                if (pick == 2)
                    q.operand_lo[51:0] = 52'd1 << $urandom_range(0, 51);
            end
            default:
            begin
                if (pick < 2)
                    q.operand_lo[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h0;
                if (pick == 2)
                    q.operand_lo[22:0] = 23'd1 << $urandom_range(0, 22);
            end
        endcase
        return q;
    endfunction

    function automatic ffc_req_t make_req(logic [2:0] k, logic [63:0] hi, logic [63:0] lo);
        ffc_req_t q;
        q.kind = k;
        q.operand_hi = hi;
        q.operand_lo = lo;
        return q;
    endfunction

    // Fill the request queue: directed corners, then random traffic.
    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        // quad below double min normal, max finite, inf, nan, subnormal, overflow to d/s
        pending_reqs.push_back(make_req(KIND_Q2D, 64'h3c00000000000000, 64'h0));
        pending_reqs.push_back(make_req(KIND_Q2D, 64'h43feffffffffffff, 64'hf800000000000000));
        pending_reqs.push_back(make_req(KIND_Q2D, 64'hffff000000000000, 64'h0));
        pending_reqs.push_back(make_req(KIND_Q2D, 64'hffff000000000000, 64'h1));
        pending_reqs.push_back(make_req(KIND_Q2D, 64'h8000ffffffffffff, 64'hffffffffffffffff));
        pending_reqs.push_back(make_req(KIND_Q2D, 64'h3bcd000000000000, 64'h0));
        pending_reqs.push_back(make_req(KIND_Q2D, 64'h3bff000000000000, 64'h0800000000000000));
        pending_reqs.push_back(make_req(KIND_Q2S, 64'h407effffff000000, 64'h0));
        pending_reqs.push_back(make_req(KIND_Q2S, 64'h3f81000000000000, 64'h1));
        pending_reqs.push_back(make_req(KIND_Q2S, 64'h3f68000000000000, 64'h0));
        pending_reqs.push_back(make_req(KIND_Q2S, 64'h7fff800000000000, 64'h0));
        pending_reqs.push_back(make_req(KIND_D2S, 64'h0, 64'h47efffffe0000000));
        pending_reqs.push_back(make_req(KIND_D2S, 64'h0, 64'h000fffffffffffff));
        pending_reqs.push_back(make_req(KIND_D2S, 64'h0, 64'hb690000000000001));
        pending_reqs.push_back(make_req(KIND_D2S, 64'h0, 64'hfff0000000000000));
        pending_reqs.push_back(make_req(KIND_D2S, 64'h0, 64'h7ff0000000000001));
        pending_reqs.push_back(make_req(KIND_S2D, 64'hffffffffffffffff, 64'hffffffff00000001));
        pending_reqs.push_back(make_req(KIND_S2D, 64'h0, 64'h00000000ff800001));
        pending_reqs.push_back(make_req(KIND_S2D, 64'h0, 64'h000000007f7fffff));
        pending_reqs.push_back(make_req(KIND_D2Q, 64'hffffffffffffffff, 64'h8000000000000001));
        pending_reqs.push_back(make_req(KIND_D2Q, 64'h0, 64'h7fefffffffffffff));
        pending_reqs.push_back(make_req(KIND_D2Q, 64'h0, 64'hfff8000000000000));
        pending_reqs.push_back(make_req(KIND_S2Q, 64'h0, 64'hffffffff80000000));
        pending_reqs.push_back(make_req(KIND_S2Q, 64'h0, 64'h000000007f800000));
        pending_reqs.push_back(make_req(3'd6, 64'hffffffffffffffff, 64'hffffffffffffffff));
        pending_reqs.push_back(make_req(3'd7, 64'h1, 64'h1));
        repeat (RANDOM_REQS)
            pending_reqs.push_back(random_request());
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Quiet window: no idling on either side for a stretch mid-run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        quiet_window <= (cycle_count > 900 && cycle_count < 1300);
    end

    // Driver: present the next request; advance on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.data  <= '0;
        end
        else if (!req.valid || req.ready)
        begin
            if (req.valid)
                expected_results.push_back(convert_expected(req.data));
            if (pending_reqs.size() != 0 &&
                (quiet_window || $urandom_range(0, 99) >= 35))
            begin
                req.valid <= 1'b1;
                req.data  <= pending_reqs.pop_front();
            end
            else
                req.valid <= 1'b0;
        end
    end

    // Monitor: check each accepted result and drive a random stall.
    always @(posedge clk or negedge rst_n)
    begin
        ffc_rsp_t exp_r;
        int       mismatches;
        mismatches = 0;
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing outstanding: %h %h",
                           rsp.data.result_hi, rsp.data.result_lo);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (rsp.data.result_hi !== exp_r.result_hi)
                    begin
                        $error("result_hi expected %h actual %h",
                               exp_r.result_hi, rsp.data.result_hi);
                        mismatches = mismatches + 1;
                    end
                    if (rsp.data.result_lo !== exp_r.result_lo)
                    begin
                        $error("result_lo expected %h actual %h",
                               exp_r.result_lo, rsp.data.result_lo);
                        mismatches = mismatches + 1;
                    end
                end
                if (mismatches != 0)
                    error_count <= error_count + mismatches;
            end
            rsp.ready <= quiet_window || ($urandom_range(0, 99) >= 35);
        end
    end

    // Watchdog: count cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("float_format_converter_unit regression: fail");
            $finish;
        end
    end

    // Finish once all requests are drained and results are checked.
    initial
    begin
        error_count = 0;
        results_seen = 0;
        idle_cycles = 0;
        cycle_count = 0;
        quiet_window = 1'b0;
        wait (rst_n === 1'b1);
        wait (pending_reqs.size() == 0 && !req.valid);
        wait (expected_results.size() == 0);
        repeat (10) @(posedge clk);
        $display("Checked %0d conversions across all six directions and unknown kinds,",
                 results_seen);
        $display("including rounding, overflow, subnormal and NaN corners.");
        if (error_count == 0 && expected_results.size() == 0)
            $display("float_format_converter_unit regression: pass");
        else
            $display("float_format_converter_unit regression: fail");
        $finish;
    end
endmodule
